>>> hdl/zssb_pkg.sv
// Shared constants and types for the zero-sum subset balancer.
package zssb_pkg;

    localparam int MAX_ITEMS  = 16;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int MASK_W     = MAX_ITEMS;
    localparam int SUM_W      = 36;
    localparam int PROD_W     = 37;
    localparam int DEV_W      = 34;
    localparam int RUN_W      = 38;
    localparam int AMT_W      = 36;
    localparam int DIV_STEPS  = SUM_W;
    localparam int DP_DEPTH   = 1 << MASK_W;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NDIV = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef struct packed {
        logic             bal;
        logic [IDX_W-1:0] lr;
        logic [CNT_W-1:0] cost;
    } dp_ent_t;

    localparam int ENT_W = $bits(dp_ent_t);

endpackage

>>> hdl/zssb_if.sv
// Channel interfaces: input items and result items.
interface zssb_in_if import zssb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic                  last_value;

    modport source (output valid, value, last_value, input ready);
    modport sink (input valid, value, last_value, output ready);
endinterface

interface zssb_out_if import zssb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic             has_transfer;
    logic [3:0]       giver;
    logic [3:0]       taker;
    logic [AMT_W-1:0] amount;
    logic [3:0]       transfer_total;
    logic             last_result;

    modport source (output valid, status, has_transfer, giver, taker, amount,
                    transfer_total, last_result, input ready);
    modport sink (input valid, status, has_transfer, giver, taker, amount,
                  transfer_total, last_result, output ready);
endinterface

>>> hdl/zssb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module zssb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/zero_sum_subset_balancer.sv
// Top level: minimum-transfer balancer over a subset-mask DP.
//
// Usage: values arrive on the items channel, one per transfer; last_value
// marks the final value of a set. Up to 16 values are kept; more are
// dropped and the set reports status 2. After the final value the block
// sums the set, divides by the count (one quotient bit per cycle) and,
// if the division is exact, runs the DP over all 2^n masks through one
// 64K-entry RAM with one read port: each mask is scanned over its n
// items, finished and then written back. The walk back and per-group
// selection scan follow. Results leave through a single output
// register; a stalled receiver holds the sequencer in its result or
// emit state without losing anything.
// items.ready is high only while the block waits for input.
// Reset clears the sequencer, the item count and the overflow flag; the DP
// RAM needs no clearing, since each run rewrites every mask it reads.
module zero_sum_subset_balancer import zssb_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    zssb_in_if.sink    items,
    zssb_out_if.source results
);

    typedef enum logic [14:0] {
        S_IDLE    = 15'h0001,
        S_RES     = 15'h0002,
        S_SUM     = 15'h0004,
        S_DIV     = 15'h0008,
        S_INIT    = 15'h0010,
        S_DP_SCAN = 15'h0020,
        S_DP_FIN  = 15'h0040,
        S_DP_WR   = 15'h0080,
        S_WB_RD   = 15'h0100,
        S_WB_GET  = 15'h0200,
        S_SEL     = 15'h0400,
        S_SEL_END = 15'h0800,
        S_EMIT    = 15'h1000,
        S_SPARE0  = 15'h2000,
        S_SPARE1  = 15'h4000
    } state_t;

    state_t state_reg, state_next;

    logic [VALUE_BITS-1:0] vals_reg [MAX_ITEMS];
    logic                  vals_we;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [MASK_W-1:0]     full_reg, full_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [SUM_W-1:0]      dvd_reg, dvd_next;
    logic [IDX_W-1:0]      rem_reg, rem_next;
    logic [5:0]            dcnt_reg, dcnt_next;
    logic [VALUE_BITS-1:0] avg_reg, avg_next;
    logic [1:0]            status_reg, status_next;
    logic [MASK_W-1:0]     mask_reg, mask_next;
    logic [CNT_W-1:0]      best_reg, best_next;
    logic [IDX_W-1:0]      lr_reg, lr_next;
    logic                  pend_reg, pend_next;
    logic [IDX_W-1:0]      pidx_reg, pidx_next;
    logic [SUM_W-1:0]      sumv_reg, sumv_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [MASK_W-1:0]     cur_reg, cur_next;
    logic [MASK_W-1:0]     grp_reg, grp_next;
    logic [CNT_W-1:0]      g_reg, g_next;
    logic                  first_reg, first_next;
    logic [3:0]            total_reg, total_next;
    logic [MASK_W-1:0]     srem_reg, srem_next;
    logic [CNT_W-1:0]      a_reg, a_next;
    logic                  have_reg, have_next;
    logic [VALUE_BITS-1:0] bv_reg, bv_next;
    logic [IDX_W-1:0]      bidx_reg, bidx_next;
    logic signed [DEV_W-1:0] dev_reg, dev_next;
    logic [IDX_W-1:0]      p_reg, p_next;
    logic [IDX_W-1:0]      prev_reg, prev_next;
    logic signed [RUN_W-1:0] run_reg, run_next;
    logic [3:0]            ecnt_reg, ecnt_next;

    logic                  ovalid_reg, ovalid_next;
    logic [1:0]            ostatus_reg, ostatus_next;
    logic                  ohas_reg, ohas_next;
    logic [3:0]            ogiver_reg, ogiver_next;
    logic [3:0]            otaker_reg, otaker_next;
    logic [AMT_W-1:0]      oamt_reg, oamt_next;
    logic [3:0]            ototal_reg, ototal_next;
    logic                  olast_reg, olast_next;

    logic                  ram_we;
    logic [MASK_W-1:0]     ram_waddr;
    dp_ent_t               ram_wdata;
    logic [MASK_W-1:0]     ram_raddr;
    dp_ent_t               ram_rdata;

    logic [VALUE_BITS-1:0] vcur;
    logic                  idx_last;
    logic                  out_free;
    logic                  accept;
    logic [CNT_W-1:0]      dtmp;
    logic signed [DEV_W-1:0] dev_w;
    logic [MASK_W:0]       full_w;
    logic                  grp_end;

    zssb_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DP_DEPTH)
    ) u_dp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign vcur     = vals_reg[idx_reg];
    assign idx_last = ({1'b0, idx_reg} == (n_reg - CNT_W'(1)));
    assign out_free = !ovalid_reg || results.ready;
    assign accept   = items.valid && items.ready;
    assign dtmp     = {rem_reg, dvd_reg[SUM_W-1]};
    assign dev_w    = DEV_W'(signed'({2'b00, bv_reg})) - DEV_W'(signed'({2'b00, avg_reg}));
    assign full_w   = ((MASK_W+1)'(1) << (count_reg + CNT_W'(1))) - (MASK_W+1)'(1);
    assign vals_we  = accept && (count_reg < CNT_W'(MAX_ITEMS));

    assign items.ready            = (state_reg == S_IDLE);
    assign results.valid          = ovalid_reg;
    assign results.status         = ostatus_reg;
    assign results.has_transfer   = ohas_reg;
    assign results.giver          = ogiver_reg;
    assign results.taker          = otaker_reg;
    assign results.amount         = oamt_reg;
    assign results.transfer_total = ototal_reg;
    assign results.last_result    = olast_reg;

    always_ff @(posedge clk)
    begin
        if (vals_we)
        begin
            vals_reg[count_reg[IDX_W-1:0]] <= items.value;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        n_next       = n_reg;
        full_next    = full_reg;
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        dcnt_next    = dcnt_reg;
        avg_next     = avg_reg;
        status_next  = status_reg;
        mask_next    = mask_reg;
        best_next    = best_reg;
        lr_next      = lr_reg;
        pend_next    = pend_reg;
        pidx_next    = pidx_reg;
        sumv_next    = sumv_reg;
        prod_next    = prod_reg;
        cur_next     = cur_reg;
        grp_next     = grp_reg;
        g_next       = g_reg;
        first_next   = first_reg;
        total_next   = total_reg;
        srem_next    = srem_reg;
        a_next       = a_reg;
        have_next    = have_reg;
        bv_next      = bv_reg;
        bidx_next    = bidx_reg;
        dev_next     = dev_reg;
        p_next       = p_reg;
        prev_next    = prev_reg;
        run_next     = run_reg;
        ecnt_next    = ecnt_reg;
        ovalid_next  = ovalid_reg && !results.ready;
        ostatus_next = ostatus_reg;
        ohas_next    = ohas_reg;
        ogiver_next  = ogiver_reg;
        otaker_next  = otaker_reg;
        oamt_next    = oamt_reg;
        ototal_next  = ototal_reg;
        olast_next   = olast_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_raddr    = '0;
        grp_end      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (count_reg < CNT_W'(MAX_ITEMS))
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (items.last_value)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        if (ovf_reg || (count_reg == CNT_W'(MAX_ITEMS)))
                        begin
                            status_next = ST_OVF;
                            state_next  = S_RES;
                        end
                        else
                        begin
                            n_next     = count_reg + CNT_W'(1);
                            full_next  = full_w[MASK_W-1:0];
                            idx_next   = '0;
                            sum_next   = '0;
                            state_next = S_SUM;
                        end
                    end
                end
            end

            S_RES:
            begin
                if (out_free)
                begin
                    ovalid_next  = 1'b1;
                    ostatus_next = status_reg;
                    ohas_next    = 1'b0;
                    ogiver_next  = '0;
                    otaker_next  = '0;
                    oamt_next    = '0;
                    ototal_next  = '0;
                    olast_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            S_SUM:
            begin
                sum_next = sum_reg + SUM_W'(vcur);
                idx_next = idx_reg + IDX_W'(1);
                if (idx_last)
                begin
                    dvd_next   = sum_reg + SUM_W'(vcur);
                    rem_next   = '0;
                    dcnt_next  = '0;
                    idx_next   = '0;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (dtmp >= n_reg)
                begin
                    rem_next = IDX_W'(dtmp - n_reg);
                    dvd_next = {dvd_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = dtmp[IDX_W-1:0];
                    dvd_next = {dvd_reg[SUM_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == 6'(DIV_STEPS - 1))
                begin
                    avg_next = dvd_next[VALUE_BITS-1:0];
                    if (rem_next != '0)
                    begin
                        status_next = ST_NDIV;
                        state_next  = S_RES;
                    end
                    else
                    begin
                        state_next = S_INIT;
                    end
                end
            end

            S_INIT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = '{bal: 1'b1, lr: '0, cost: '0};
                mask_next  = MASK_W'(1);
                idx_next   = '0;
                best_next  = n_reg + CNT_W'(1);
                lr_next    = '0;
                pend_next  = 1'b0;
                sumv_next  = '0;
                prod_next  = '0;
                state_next = S_DP_SCAN;
            end

            S_DP_SCAN:
            begin
                if (pend_reg && (best_reg > ram_rdata.cost))
                begin
                    best_next = ram_rdata.cost;
                    lr_next   = pidx_reg;
                end
                pend_next = mask_reg[idx_reg];
                pidx_next = idx_reg;
                ram_raddr = mask_reg ^ (MASK_W'(1) << idx_reg);
                if (mask_reg[idx_reg])
                begin
                    sumv_next = sumv_reg + SUM_W'(vcur);
                    prod_next = prod_reg + PROD_W'(avg_reg);
                end
                idx_next = idx_reg + IDX_W'(1);
                if (idx_last)
                begin
                    idx_next   = '0;
                    state_next = S_DP_FIN;
                end
            end

            S_DP_FIN:
            begin
                if (pend_reg && (best_reg > ram_rdata.cost))
                begin
                    best_next = ram_rdata.cost;
                    lr_next   = pidx_reg;
                end
                pend_next  = 1'b0;
                state_next = S_DP_WR;
            end

            S_DP_WR:
            begin
                ram_we         = 1'b1;
                ram_waddr      = mask_reg;
                ram_wdata.bal  = (PROD_W'(sumv_reg) == prod_reg);
                ram_wdata.lr   = lr_reg;
                ram_wdata.cost = best_reg + ((PROD_W'(sumv_reg) == prod_reg) ?
                                             CNT_W'(0) : CNT_W'(1));
                if (mask_reg == full_reg)
                begin
                    cur_next   = full_reg;
                    g_next     = '0;
                    grp_next   = '0;
                    first_next = 1'b1;
                    ecnt_next  = '0;
                    state_next = S_WB_RD;
                end
                else
                begin
                    mask_next  = mask_reg + MASK_W'(1);
                    best_next  = n_reg + CNT_W'(1);
                    lr_next    = '0;
                    sumv_next  = '0;
                    prod_next  = '0;
                    state_next = S_DP_SCAN;
                end
            end

            S_WB_RD:
            begin
                ram_raddr  = cur_reg;
                state_next = S_WB_GET;
            end

            S_WB_GET:
            begin
                if (first_reg && (ram_rdata.cost == '0))
                begin
                    status_next = ST_OK;
                    state_next  = S_RES;
                end
                else
                begin
                    first_next = 1'b0;
                    if (first_reg)
                    begin
                        total_next = ram_rdata.cost[3:0];
                    end
                    if ((g_reg != '0) &&
                        (ram_rdata.bal || (g_reg == CNT_W'(MAX_ITEMS))))
                    begin
                        srem_next  = grp_reg;
                        a_next     = '0;
                        idx_next   = '0;
                        have_next  = 1'b0;
                        state_next = S_SEL;
                    end
                    else
                    begin
                        grp_next   = grp_reg | (MASK_W'(1) << ram_rdata.lr);
                        cur_next   = cur_reg & ~(MASK_W'(1) << ram_rdata.lr);
                        g_next     = g_reg + CNT_W'(1);
                        state_next = S_WB_RD;
                    end
                end
            end

            S_SEL:
            begin
                // highest value first; ascending scan keeps lower index on ties
                if (srem_reg[idx_reg] && (!have_reg || (vcur > bv_reg)))
                begin
                    bv_next   = vcur;
                    bidx_next = idx_reg;
                    have_next = 1'b1;
                end
                idx_next = idx_reg + IDX_W'(1);
                if (idx_last)
                begin
                    idx_next   = '0;
                    state_next = S_SEL_END;
                end
            end

            S_SEL_END:
            begin
                if (a_reg == '0)
                begin
                    run_next  = RUN_W'(dev_w);
                    prev_next = bidx_reg;
                    srem_next = srem_reg & ~(MASK_W'(1) << bidx_reg);
                    a_next    = CNT_W'(1);
                    have_next = 1'b0;
                    if (g_reg == CNT_W'(1))
                    begin
                        grp_end = 1'b1;
                    end
                    else
                    begin
                        state_next = S_SEL;
                    end
                end
                else
                begin
                    dev_next   = dev_w;
                    p_next     = bidx_reg;
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next  = 1'b1;
                    ostatus_next = ST_OK;
                    ohas_next    = 1'b1;
                    ogiver_next  = prev_reg;
                    otaker_next  = p_reg;
                    oamt_next    = run_reg[AMT_W-1:0];
                    ototal_next  = total_reg;
                    olast_next   = ((ecnt_reg + 4'd1) == total_reg);
                    ecnt_next    = ecnt_reg + 4'd1;
                    run_next     = run_reg + RUN_W'(dev_reg);
                    prev_next    = p_reg;
                    srem_next    = srem_reg & ~(MASK_W'(1) << p_reg);
                    a_next       = a_reg + CNT_W'(1);
                    have_next    = 1'b0;
                    if ((a_reg + CNT_W'(1)) == g_reg)
                    begin
                        grp_end = 1'b1;
                    end
                    else
                    begin
                        state_next = S_SEL;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (grp_end)
        begin
            if (cur_reg == '0)
            begin
                state_next = S_IDLE;
            end
            else
            begin
                g_next     = '0;
                grp_next   = '0;
                state_next = S_WB_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
            pend_reg   <= 1'b0;
            first_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            ovalid_reg <= ovalid_next;
            pend_reg   <= pend_next;
            first_reg  <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        full_reg    <= full_next;
        idx_reg     <= idx_next;
        sum_reg     <= sum_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        dcnt_reg    <= dcnt_next;
        avg_reg     <= avg_next;
        status_reg  <= status_next;
        mask_reg    <= mask_next;
        best_reg    <= best_next;
        lr_reg      <= lr_next;
        pidx_reg    <= pidx_next;
        sumv_reg    <= sumv_next;
        prod_reg    <= prod_next;
        cur_reg     <= cur_next;
        grp_reg     <= grp_next;
        g_reg       <= g_next;
        total_reg   <= total_next;
        srem_reg    <= srem_next;
        a_reg       <= a_next;
        have_reg    <= have_next;
        bv_reg      <= bv_next;
        bidx_reg    <= bidx_next;
        dev_reg     <= dev_next;
        p_reg       <= p_next;
        prev_reg    <= prev_next;
        run_reg     <= run_next;
        ecnt_reg    <= ecnt_next;
        ostatus_reg <= ostatus_next;
        ohas_reg    <= ohas_next;
        ogiver_reg  <= ogiver_next;
        otaker_reg  <= otaker_next;
        oamt_reg    <= oamt_next;
        ototal_reg  <= ototal_next;
        olast_reg   <= olast_next;
    end

`ifndef SYNTHESIS
    a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && (results.status != ST_OK)
        |-> results.last_result && !results.has_transfer)
        else $error("error result not final or carries a transfer");

    a_xfer_total: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.has_transfer |-> results.transfer_total != '0)
        else $error("transfer with zero total");

    a_dp_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DP_WR) |-> (mask_reg != '0))
        else $error("DP write to mask zero");
`endif

endmodule
